### src/slcan_line_receiver_unit_assert.svh
// Assertion macros used by the line receiver's back stage
`ifndef SLCAN_LINE_RECEIVER_UNIT_ASSERT_SVH
`define SLCAN_LINE_RECEIVER_UNIT_ASSERT_SVH

// same-cycle implication, checked on clk, off while rst is high
`define SLCAN_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on clk, off while rst is high
`define SLCAN_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/slcan_pkg.sv
// Package: field widths, character codes, line kinds and the token type
`default_nettype none

package slcan_pkg;

  localparam int PRIO_BITS = 1;
  localparam int TYPE_BITS = 5;
  localparam int SEQ_BITS  = 5;
  localparam int DEST_BITS = 9;
  localparam int SRC_BITS  = 9;

  localparam int SRC_SHIFT  = 0;
  localparam int DEST_SHIFT = SRC_BITS;
  localparam int SEQ_SHIFT  = DEST_BITS + SRC_BITS;
  localparam int TYPE_SHIFT = SEQ_BITS + DEST_BITS + SRC_BITS;
  localparam int PRIO_SHIFT = TYPE_BITS + SEQ_BITS + DEST_BITS + SRC_BITS;

  localparam int ID_BITS   = 32;
  localparam int DATA_BITS = 64;
  localparam int DATA_NIBS = DATA_BITS / 4;
  localparam int CNT_BITS  = 5;

  localparam logic [CNT_BITS-1:0] MAX_LINE  = CNT_BITS'(27);
  localparam logic [CNT_BITS-1:0] COUNT_MAX = CNT_BITS'(31);
  // characters in front of the first data digit: 'T', 8 id digits, DLC
  localparam logic [CNT_BITS-1:0] HDR_LEN   = CNT_BITS'(10);
  localparam logic [CNT_BITS-1:0] DLC_POS   = CNT_BITS'(9);
  localparam logic [CNT_BITS-1:0] ID_LAST   = CNT_BITS'(8);
  localparam logic [CNT_BITS-1:0] DATA_SPAN = CNT_BITS'(DATA_NIBS);

  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_T   = 8'h54;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_FRAME   = 2'd0,
    KIND_ACK     = 2'd1,
    KIND_NACK    = 2'd2,
    KIND_INVALID = 2'd3
  } line_kind_t;

  // one classified character
  typedef struct packed {
    logic       is_term;
    logic       is_cr;
    logic       is_t;
    logic       hex_ok;
    logic [3:0] hex_val;
    logic       dlc_ok;
    logic [3:0] dlc_val;
  } tok_t;

endpackage

`default_nettype wire

### src/slcan_rx_if.sv
// Character input channel
`default_nettype none

interface slcan_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### src/slcan_res_if.sv
// Line result channel
`default_nettype none

interface slcan_res_if
  import slcan_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [1:0]           line_kind;
  logic [ID_BITS-1:0]   frame_id;
  logic [PRIO_BITS-1:0] priority_res;
  logic [TYPE_BITS-1:0] msg_type;
  logic [SEQ_BITS-1:0]  seq_number;
  logic [DEST_BITS-1:0] dest_node;
  logic [SRC_BITS-1:0]  src_node;
  logic [3:0]           data_len;
  logic [DATA_BITS-1:0] payload;

  modport source (output valid, output line_kind, output frame_id, output priority_res,
                  output msg_type, output seq_number, output dest_node, output src_node,
                  output data_len, output payload, input ready);
  modport sink (input valid, input line_kind, input frame_id, input priority_res,
                input msg_type, input seq_number, input dest_node, input src_node,
                input data_len, input payload, output ready);
endinterface

`default_nettype wire

### src/slcan_line_receiver_unit.sv
// SLCAN line receiver: top level joining front stage, token queue and back stage
//
// Channel rx carries one ASCII character per word; channel res carries one
// result word per line, sent when CR or BEL ends it. A lone terminator gives
// ack (CR) or nack (BEL); a well formed 'T' line gives a frame with the raw
// 32-bit id, its split fields, the DLC and left aligned data; anything else
// gives invalid with all other fields zero.
// Throughput: one character per cycle while res takes its results; see Stall.
// A terminator passes through the front register, a queue entry and the
// result register before its result shows on res; it waits longer in the
// queue only while res is held.
// Stall: while res is held off, characters keep flowing into the back stage;
// the next terminator waits in the queue, and once the queue and the front
// register fill, rx.ready drops.
// Reset (rst, synchronous): empties the queue and front register, clears the
// line state and drops res.valid; the first character after it starts a line.
`default_nettype none

module slcan_line_receiver_unit
  import slcan_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  slcan_rx_if.sink    rx,
  slcan_res_if.source res
);

  logic f_valid;
  logic f_ready;
  tok_t f_tok;
  logic b_valid;
  logic b_ready;
  tok_t b_tok;

  slcan_front u_front (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .tok_valid (f_valid),
    .tok_ready (f_ready),
    .tok       (f_tok)
  );

  slcan_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_tok   (f_tok),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_tok    (b_tok)
  );

  slcan_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok_valid (b_valid),
    .tok_ready (b_ready),
    .tok       (b_tok),
    .res       (res)
  );

endmodule

`default_nettype wire

### src/slcan_front.sv
// Front stage: takes a character word and registers its classification
`default_nettype none

module slcan_front
  import slcan_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  slcan_rx_if.sink  rx,
  output logic      tok_valid,
  input  wire logic tok_ready,
  output tok_t      tok
);

  tok_t tok_in;
  logic [7:0] c;

  assign c = rx.rx_byte;

  always_comb begin
    tok_in         = '0;
    tok_in.is_term = (c == CH_CR) || (c == CH_BEL);
    tok_in.is_cr   = (c == CH_CR);
    tok_in.is_t    = (c == CH_T);
    // any other character leaves hex_ok clear
    if (c >= 8'h30 && c <= 8'h39) begin
      tok_in.hex_ok  = 1'b1;
      tok_in.hex_val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      tok_in.hex_ok  = 1'b1;
      tok_in.hex_val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      tok_in.hex_ok  = 1'b1;
      tok_in.hex_val = 4'(c - 8'h57);
    end
    tok_in.dlc_ok  = (c >= 8'h30) && (c <= 8'h38);
    tok_in.dlc_val = 4'(c - 8'h30);
  end

  assign rx.ready = !tok_valid || tok_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else if (rx.valid && rx.ready) begin
      tok_valid <= 1'b1;
    end else if (tok_ready) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      tok <= tok_in;
    end
  end

endmodule

`default_nettype wire

### src/slcan_queue.sv
// Short token queue between the front and back stages
`default_nettype none

module slcan_queue
  import slcan_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push_valid,
  output logic      push_ready,
  input  wire tok_t push_tok,
  output logic      pop_valid,
  input  wire logic pop_ready,
  output tok_t      pop_tok
);

  tok_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign push_ready = (fill != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_tok    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_tok;
    end
  end

endmodule

`default_nettype wire

### src/slcan_back.sv
// Back stage: line state, frame check and the result register
`default_nettype none
`include "slcan_line_receiver_unit_assert.svh"

module slcan_back
  import slcan_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   tok_valid,
  output logic        tok_ready,
  input  wire tok_t   tok,
  slcan_res_if.source res
);

  logic [CNT_BITS-1:0]        line_count, line_count_next;
  logic                       first_t, first_t_next;
  logic [ID_BITS-1:0]         id_accum, id_accum_next;
  logic [3:0]                 len_digit, len_digit_next;
  logic [DATA_NIBS-1:0][3:0]  data_nib, data_nib_next;
  logic                       bad_line, bad_line_next;

  logic                pop;
  logic                term;
  logic [CNT_BITS-1:0] n;
  logic [CNT_BITS-1:0] need_len;
  logic                frame_ok;
  line_kind_t          kind;

  // a terminator needs room in the result register; other words never stall
  assign tok_ready = !tok.is_term || !res.valid || res.ready;
  assign pop       = tok_valid && tok_ready;
  assign term      = pop && tok.is_term;

  assign n        = line_count - HDR_LEN;
  assign need_len = HDR_LEN + {len_digit, 1'b0};
  assign frame_ok = first_t && !bad_line && (line_count < MAX_LINE) &&
                    (line_count >= HDR_LEN) && (line_count >= need_len);

  always_comb begin
    priority if (line_count == '0) begin
      kind = tok.is_cr ? KIND_ACK : KIND_NACK;
    end else if (frame_ok) begin
      kind = KIND_FRAME;
    end else begin
      kind = KIND_INVALID;
    end
  end

  always_comb begin
    line_count_next = line_count;
    first_t_next    = first_t;
    id_accum_next   = id_accum;
    len_digit_next  = len_digit;
    data_nib_next   = data_nib;
    bad_line_next   = bad_line;
    if (term) begin
      line_count_next = '0;
      first_t_next    = 1'b0;
      id_accum_next   = '0;
      len_digit_next  = '0;
      data_nib_next   = '0;
      bad_line_next   = 1'b0;
    end else if (pop) begin
      priority if (line_count == '0) begin
        first_t_next = tok.is_t;
      end else if (line_count <= ID_LAST) begin
        if (tok.hex_ok) begin
          id_accum_next = {id_accum[ID_BITS-5:0], tok.hex_val};
        end else begin
          bad_line_next = 1'b1;
        end
      end else if (line_count == DLC_POS) begin
        if (tok.dlc_ok) begin
          len_digit_next = tok.dlc_val;
        end else begin
          bad_line_next = 1'b1;
        end
      end else begin
        // data digits fill from the top nibble down; trailing characters are ignored
        if ((n < {len_digit, 1'b0}) && (n < DATA_SPAN)) begin
          if (tok.hex_ok) begin
            data_nib_next[4'(DATA_NIBS - 1) - n[3:0]] = tok.hex_val;
          end else begin
            bad_line_next = 1'b1;
          end
        end
      end
      if (line_count != COUNT_MAX) begin
        line_count_next = line_count + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_count <= '0;
      first_t    <= 1'b0;
      id_accum   <= '0;
      len_digit  <= '0;
      data_nib   <= '0;
      bad_line   <= 1'b0;
      res.valid  <= 1'b0;
    end else begin
      line_count <= line_count_next;
      first_t    <= first_t_next;
      id_accum   <= id_accum_next;
      len_digit  <= len_digit_next;
      data_nib   <= data_nib_next;
      bad_line   <= bad_line_next;
      if (term) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (term) begin
      res.line_kind <= kind;
      if (kind == KIND_FRAME) begin
        res.frame_id     <= id_accum;
        res.priority_res <= id_accum[PRIO_SHIFT +: PRIO_BITS];
        res.msg_type     <= id_accum[TYPE_SHIFT +: TYPE_BITS];
        res.seq_number   <= id_accum[SEQ_SHIFT +: SEQ_BITS];
        res.dest_node    <= id_accum[DEST_SHIFT +: DEST_BITS];
        res.src_node     <= id_accum[SRC_SHIFT +: SRC_BITS];
        res.data_len     <= len_digit;
        res.payload      <= data_nib;
      end else begin
        res.frame_id     <= '0;
        res.priority_res <= '0;
        res.msg_type     <= '0;
        res.seq_number   <= '0;
        res.dest_node    <= '0;
        res.src_node     <= '0;
        res.data_len     <= '0;
        res.payload      <= '0;
      end
    end
  end

  `SLCAN_ASSERT_NEXT(a_term_clears, term, line_count == '0 && !bad_line, "line state not cleared")
  `SLCAN_ASSERT_NOW(a_slot_free, term, !res.valid || res.ready, "result overwritten")
  `SLCAN_ASSERT_NOW(a_res_source, $rose(res.valid), $past(term), "result without terminator")
  `SLCAN_ASSERT_NOW(a_bad_sticky, $fell(bad_line), $past(rst) || $past(term), "bad flag lost")

endmodule

`default_nettype wire

### sim/slcan_line_receiver_unit_tb.sv
// Testbench for the SLCAN line receiver: line-level stimulus, predictor and scoreboard
`timescale 1ns / 100ps

module slcan_line_receiver_unit_tb
  import slcan_pkg::*;
;

  localparam int HOLD_LEN       = 200;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_CHARS    = 370;
  localparam int SETTLE_CYCLES  = 8;

  typedef struct packed {
    line_kind_t           kind;
    logic [ID_BITS-1:0]   id;
    logic [PRIO_BITS-1:0] prio;
    logic [TYPE_BITS-1:0] mtype;
    logic [SEQ_BITS-1:0]  seq;
    logic [DEST_BITS-1:0] dest;
    logic [SRC_BITS-1:0]  src;
    logic [3:0]           dlc;
    logic [DATA_BITS-1:0] data;
  } line_res_t;

  // Predicts one result per terminator and matches the block's results in order
  class line_scoreboard;
    line_res_t          expected_q[$];
    logic [CNT_BITS-1:0] line_count;
    logic [7:0]          first_char;
    logic [ID_BITS-1:0]  id_acc;
    logic [3:0]          dlc_acc;
    logic [DATA_BITS-1:0] data_acc;
    bit                  bad_line;
    int n_checked, n_errors, n_frames, n_acks, n_nacks, n_invalid;

    function new();
      clear_line();
    endfunction

    function void clear_line();
      line_count = '0;
      first_char = '0;
      id_acc     = '0;
      dlc_acc    = '0;
      data_acc   = '0;
      bad_line   = 1'b0;
    endfunction

    // 16 marks a character that is not a hex digit
    function logic [4:0] hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return 5'(c - "0");
      if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
      if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
      return 5'd16;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_char(logic [7:0] c);
      line_res_t r;
      int cnt;
      int n;
      logic [4:0] v;
      cnt = line_count;
      if (c == CH_CR || c == CH_BEL) begin
        r = '0;
        if (cnt == 0) begin
          r.kind = (c == CH_CR) ? KIND_ACK : KIND_NACK;
        end else if (first_char == CH_T && !bad_line && cnt <= MAX_LINE - 1 && cnt >= 10 &&
                     dlc_acc <= 8 && cnt >= 10 + 2 * dlc_acc) begin
          r.kind  = KIND_FRAME;
          r.id    = id_acc;
          r.prio  = id_acc[PRIO_SHIFT +: PRIO_BITS];
          r.mtype = id_acc[TYPE_SHIFT +: TYPE_BITS];
          r.seq   = id_acc[SEQ_SHIFT +: SEQ_BITS];
          r.dest  = id_acc[DEST_SHIFT +: DEST_BITS];
          r.src   = id_acc[SRC_SHIFT +: SRC_BITS];
          r.dlc   = dlc_acc;
          r.data  = data_acc;
        end else begin
          r.kind = KIND_INVALID;
        end
        case (r.kind)
          KIND_FRAME: n_frames++;
          KIND_ACK:   n_acks++;
          KIND_NACK:  n_nacks++;
          default:    n_invalid++;
        endcase
        expected_q.push_back(r);
        clear_line();
        return;
      end
      if (cnt == 0) begin
        first_char = c;
      end else if (cnt <= ID_LAST) begin
        v = hex_nibble(c);
        if (v[4]) bad_line = 1'b1;
        else id_acc = {id_acc[ID_BITS-5:0], v[3:0]};
      end else if (cnt == DLC_POS) begin
        if (c >= "0" && c <= "8") dlc_acc = 4'(c - "0");
        else bad_line = 1'b1;
      end else begin
        // data digits past the DLC are trailing characters and go unchecked
        n = cnt - HDR_LEN;
        if (n < 2 * dlc_acc && n < DATA_NIBS) begin
          v = hex_nibble(c);
          if (v[4]) bad_line = 1'b1;
          else data_acc |= DATA_BITS'(v[3:0]) << (DATA_BITS - 4 - 4 * n);
        end
      end
      if (line_count != COUNT_MAX) line_count++;
    endfunction

    function void cmp_field(string name, logic [63:0] e, logic [63:0] a);
      if (e !== a) begin
        n_errors++;
        if (n_errors <= 10)
          $display("result %0d: field %s expected %h, got %h", n_checked, name, e, a);
      end
    endfunction

    function void check_result(line_res_t got);
      line_res_t e;
      if (expected_q.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("result with none expected: kind %0d id %h", got.kind, got.id);
        return;
      end
      e = expected_q.pop_front();
      n_checked++;
      cmp_field("line_kind", e.kind, got.kind);
      cmp_field("frame_id", e.id, got.id);
      cmp_field("priority_res", e.prio, got.prio);
      cmp_field("msg_type", e.mtype, got.mtype);
      cmp_field("seq_number", e.seq, got.seq);
      cmp_field("dest_node", e.dest, got.dest);
      cmp_field("src_node", e.src, got.src);
      cmp_field("data_len", e.dlc, got.dlc);
      cmp_field("payload", e.data, got.data);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #5 clk = ~clk;

  slcan_rx_if  rx_ch ();
  slcan_res_if res_ch ();

  slcan_line_receiver_unit u_top (
    .clk (clk),
    .rst (rst),
    .rx  (rx_ch),
    .res (res_ch)
  );

  line_scoreboard sb = new();

  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_requests = 0;
  int hold_served   = 0;
  int n_sent        = 0;
  int idle_cycles   = 0;
  int n;
  logic [7:0] line_buf[$];

  // results are checked before the same edge's character is noted
  always @(posedge clk) begin : monitor
    line_res_t got;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        got.kind  = line_kind_t'(res_ch.line_kind);
        got.id    = res_ch.frame_id;
        got.prio  = res_ch.priority_res;
        got.mtype = res_ch.msg_type;
        got.seq   = res_ch.seq_number;
        got.dest  = res_ch.dest_node;
        got.src   = res_ch.src_node;
        got.dlc   = res_ch.data_len;
        got.data  = res_ch.payload;
        sb.check_result(got);
      end
      if (rx_ch.valid && rx_ch.ready) sb.note_char(rx_ch.rx_byte);
    end
  end

  always @(posedge clk) begin
    if (rst || (rx_ch.valid && rx_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_LEN - 1) @(negedge clk);
        hold_served++;
      end else begin
        res_ch.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      rx_ch.valid <= 1'b0;
      @(negedge clk);
    end
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_byte(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic send_str(input string s, input logic [7:0] term);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    line_buf.push_back(term);
    send_line();
  endtask

  // sender goes quiet until every expected result is back
  task automatic wait_drained();
    rx_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] v);
    if (v < 10) return 8'("0" + v);
    return $urandom_range(0, 1) ? 8'("A" + v - 10) : 8'("a" + v - 10);
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_BEL);
    return b;
  endfunction

  function automatic void build_frame(logic [31:0] id, int dlc, logic [63:0] data,
                                      int trailing, logic [7:0] term);
    line_buf.push_back(CH_T);
    for (int i = 7; i >= 0; i--) line_buf.push_back(hex_char(id[4*i +: 4]));
    line_buf.push_back(8'("0" + dlc));
    for (int i = 0; i < 2 * dlc; i++) line_buf.push_back(hex_char(data[60 - 4*i +: 4]));
    repeat (trailing) line_buf.push_back(rand_plain());
    line_buf.push_back(term);
  endfunction

  function automatic logic [31:0] rand_id();
    case ($urandom_range(0, 7))
      0:       return 32'h0;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic rand_line();
    int sel, dlc, room, len, pos, n, target;
    logic [7:0] term;
    sel  = $urandom_range(0, 99);
    dlc  = $urandom_range(0, 8);
    term = ($urandom_range(0, 3) == 0) ? CH_BEL : CH_CR;
    if (sel < 62) begin
      room = MAX_LINE - 1 - (10 + 2 * dlc);
      build_frame(rand_id(), dlc, {$urandom, $urandom},
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, room) : 0, term);
    end else if (sel < 70) begin
      line_buf.push_back(term);
    end else if (sel < 90) begin
      build_frame(rand_id(), dlc, {$urandom, $urandom}, 0, term);
      len = line_buf.size();
      case ($urandom_range(0, 4))
        0: begin
          pos = $urandom_range(1, len - 2);
          line_buf[pos] = rand_plain();
        end
        1: begin
          // too short for its DLC, or shorter than the header
          n = $urandom_range(1, 2 * dlc + 3);
          void'(line_buf.pop_back());
          repeat (n) if (line_buf.size() > 1) void'(line_buf.pop_back());
          line_buf.push_back(term);
        end
        2: begin
          // over length; past 31 the count saturates
          target = $urandom_range(MAX_LINE, 40);
          void'(line_buf.pop_back());
          while (line_buf.size() < target) line_buf.push_back(rand_plain());
          line_buf.push_back(term);
        end
        3: line_buf[DLC_POS] = $urandom_range(0, 1) ? 8'("9") : rand_plain();
        default: begin
          do line_buf[0] = rand_plain(); while (line_buf[0] == CH_T);
        end
      endcase
    end else begin
      n = $urandom_range(0, 35);
      repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
      line_buf.push_back(CH_CR);
    end
    send_line();
  endtask

  initial begin
    rx_ch.valid   = 1'b0;
    rx_ch.rx_byte = 8'h00;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed lines
    send_str("", CH_CR);
    send_str("", CH_BEL);
    send_str("T00000000", CH_CR);
    build_frame(32'hFFFF_FFFF, 8, 64'hFFFF_FFFF_FFFF_FFFF, 0, CH_BEL);
    send_line();
    send_str("T1FFFFFFF0abcdefghijklmnopq", CH_CR);   // one past the length limit
    send_str("T1234abcd1A5zz", CH_CR);                // trailing characters ignored
    send_str("T1234G678", CH_CR);                     // bad id digit
    send_str("T0000000010G", CH_CR);                  // bad data digit
    send_str("T123456789", CH_CR);                    // DLC above 8
    send_str("T123456783001", CH_CR);                 // too short for DLC
    send_str("t123", CH_BEL);                         // other command
    line_buf = '{8'h00, 8'hFF, 8'h80, 8'h7F};
    send_str("", CH_CR);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 10; rx_stall_pct = 51; end
        1: begin tx_idle_pct = 51; rx_stall_pct = 10; end
        default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
      endcase
      if (phase == 2) begin
        // receiver holds off while lines keep coming, so the input stalls
        hold_requests <= hold_requests + 1;
        repeat (24) begin
          if ($urandom_range(0, 2) == 0) rand_line();
          else send_str("", $urandom_range(0, 1) ? CH_CR : CH_BEL);
        end
      end
      n = n_sent;
      while (n_sent - n < PHASE_CHARS) begin
        rand_line();
        if (phase == 1 && n_sent - n >= PHASE_CHARS / 2 && sb.pending() != 0)
          wait_drained();
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("sent %0d characters; checked %0d results", n_sent, sb.n_checked);
    $display("lines: %0d frames, %0d ack, %0d nack, %0d invalid",
             sb.n_frames, sb.n_acks, sb.n_nacks, sb.n_invalid);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches", sb.n_errors);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/slcan_pkg.sv
src/slcan_rx_if.sv
src/slcan_res_if.sv
src/slcan_front.sv
src/slcan_queue.sv
src/slcan_back.sv
src/slcan_line_receiver_unit.sv
sim/slcan_line_receiver_unit_tb.sv
